FILE: sv/rtcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcf_pkg: shared types and constants of the continued fraction unit
// Word width, job classes and the job descriptor passed from front to back.
// ----------------------------------------------------------------------------
package rtcf_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int CNT_WIDTH   = $clog2(WORD_WIDTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEVEL_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_NORMAL,   // numerator >= denominator, both nonzero
      KIND_LEAD,     // numerator < denominator: leading zero term first
      KIND_ZERO,     // zero numerator: single term 0
      KIND_ERROR     // zero denominator: single flagged result
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [WORD_WIDTH-1:0]   dividend;
      logic [WORD_WIDTH-1:0]   divisor;
   } job_type;

endpackage

FILE: sv/rtcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcf_front: input classifier
// Sorts each item into a job class and orders the operands so that the
// back end always starts with the larger value as dividend.
// ----------------------------------------------------------------------------
module rtcf_front (
   input  logic [rtcf_pkg::WORD_WIDTH-1:0] req_numerator,
   input  logic [rtcf_pkg::WORD_WIDTH-1:0] req_denominator,
   output rtcf_pkg::job_type               job
);

   logic num_zero;
   logic den_zero;
   logic swap;

   assign num_zero = (req_numerator == '0);
   assign den_zero = (req_denominator == '0);
   assign swap     = (req_numerator < req_denominator);

   always_comb begin
      if (den_zero) begin
         job.kind = rtcf_pkg::KIND_ERROR;
      end else if (num_zero) begin
         job.kind = rtcf_pkg::KIND_ZERO;
      end else if (swap) begin
         job.kind = rtcf_pkg::KIND_LEAD;
      end else begin
         job.kind = rtcf_pkg::KIND_NORMAL;
      end
      job.dividend = swap ? req_denominator : req_numerator;
      job.divisor  = swap ? req_numerator : req_denominator;
   end

endmodule

FILE: sv/rtcf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcf_queue: job queue between classifier and divider
// Small circular buffer that lets the front accept while the back works.
// ----------------------------------------------------------------------------
module rtcf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rtcf_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output rtcf_pkg::job_type head_job
);

   rtcf_pkg::job_type mem [rtcf_pkg::QUEUE_DEPTH];

   logic [rtcf_pkg::PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rtcf_pkg::PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rtcf_pkg::LEVEL_WIDTH-1:0] level_ff, level_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (level_ff == rtcf_pkg::LEVEL_WIDTH'(rtcf_pkg::QUEUE_DEPTH));
   assign not_empty = (level_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_job  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rtcf_pkg::PTR_WIDTH'(rtcf_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rtcf_pkg::PTR_WIDTH'(rtcf_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/rtcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcf_back: Euclid sequencer with bit-serial divider
// Pops one job, emits the terms one restoring division at a time and
// swaps divisor and remainder until the remainder is zero.
// ----------------------------------------------------------------------------
module rtcf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_valid,
   input  rtcf_pkg::job_type               job,
   output logic                            job_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rtcf_pkg::WORD_WIDTH-1:0] rsp_term,
   output logic                            rsp_last_term,
   output logic                            rsp_divide_error
);

   localparam int W = rtcf_pkg::WORD_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [W-1:0]                     div_ff, div_in;
   logic [W-1:0]                     rem_ff, rem_in;
   logic [W-1:0]                     quo_ff, quo_in;
   logic [rtcf_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                             out_valid_ff, out_valid_in;
   logic [W-1:0]                     term_ff, term_in;
   logic                             last_ff, last_in;
   logic                             err_ff, err_in;

   logic                             out_free;
   logic [W:0]                       trial;
   logic [W:0]                       diff;
   logic                             fits;

   assign out_free = !out_valid_ff || !rsp_stall;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = !diff[W];

   always_comb begin
      state_in     = state_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      term_in      = term_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      job_pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid && (job.kind == rtcf_pkg::KIND_NORMAL || out_free)) begin
               job_pop = 1'b1;
               case (job.kind)
                  rtcf_pkg::KIND_ERROR: begin
                     out_valid_in = 1'b1;
                     term_in      = '0;
                     last_in      = 1'b1;
                     err_in       = 1'b1;
                  end
                  rtcf_pkg::KIND_ZERO: begin
                     out_valid_in = 1'b1;
                     term_in      = '0;
                     last_in      = 1'b1;
                     err_in       = 1'b0;
                  end
                  default: begin
                     // leading zero term goes out while the first division starts
                     if (job.kind == rtcf_pkg::KIND_LEAD) begin
                        out_valid_in = 1'b1;
                        term_in      = '0;
                        last_in      = 1'b0;
                        err_in       = 1'b0;
                     end
                     quo_in   = job.dividend;
                     div_in   = job.divisor;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_DIVIDE;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in = fits ? diff[W-1:0] : trial[W-1:0];
            quo_in = {quo_ff[W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rtcf_pkg::CNT_WIDTH'(W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               term_in      = quo_ff;
               last_in      = (rem_ff == '0);
               err_in       = 1'b0;
               if (rem_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  // advance Euclid: divisor becomes dividend, remainder divisor
                  quo_in   = div_ff;
                  div_in   = rem_ff;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      term_ff <= term_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_term         = term_ff;
   assign rsp_last_term    = last_ff;
   assign rsp_divide_error = err_ff;

   a_divisor_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (div_ff != '0))
      else $error("divider running with zero divisor");

   a_remainder_below : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor at term output");

   a_error_single : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && err_ff) |-> (last_ff && term_ff == '0))
      else $error("error result must be a single zero term");

   a_pop_idle : assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == ST_IDLE))
      else $error("job taken while an expansion is running");

endmodule

FILE: sv/rational_to_continued_fraction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_to_continued_fraction_unit: continued fraction expander
// Expands numerator/denominator into its simple continued fraction terms.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                     | handshake
//  req     | in        | req_numerator, req_denominator            | req_valid / req_stall
//  rsp     | out       | rsp_term, rsp_last_term, rsp_divide_error | rsp_valid / rsp_stall
//
//  Each term is produced one bit per cycle in the shared restoring divider,
//  and is then handed to the output register.
//  Zero-denominator and zero-numerator items skip the divider and go
//  straight from the job queue to the output register.
//  A held rsp_stall parks the divider before its next term; the two-entry
//  job queue keeps accepting items meanwhile until it is full. Reset is
//  synchronous and empties the queue and the output register.
// ----------------------------------------------------------------------------
module rational_to_continued_fraction_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rtcf_pkg::WORD_WIDTH-1:0] req_numerator,
   input  logic [rtcf_pkg::WORD_WIDTH-1:0] req_denominator,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rtcf_pkg::WORD_WIDTH-1:0] rsp_term,
   output logic                            rsp_last_term,
   output logic                            rsp_divide_error
);

   rtcf_pkg::job_type front_job;
   rtcf_pkg::job_type head_job;
   logic              queue_full;
   logic              queue_not_empty;
   logic              job_pop;

   assign req_stall = queue_full;

   rtcf_front u_front (
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .job             (front_job)
   );

   rtcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_job  (front_job),
      .full      (queue_full),
      .pop       (job_pop),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   rtcf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (queue_not_empty),
      .job              (head_job),
      .job_pop          (job_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_term         (rsp_term),
      .rsp_last_term    (rsp_last_term),
      .rsp_divide_error (rsp_divide_error)
   );

endmodule

FILE: sim/rational_to_continued_fraction_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_to_continued_fraction_unit_test: regression for the fraction expander
// Drives rationals through the request channel and checks every emitted term
// against a typed-in result or a Euclid expansion computed on the bench. A
// directed table covers zero operands, word extremes and the longest Fibonacci
// expansions, then random items; idle bursts on requests, stall bursts on results.
// ----------------------------------------------------------------------------
module rational_to_continued_fraction_unit_test;

   typedef logic [rtcf_pkg::WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type term;
      logic     last_term;
      logic     divide_error;
   } cf_term_type;

   typedef struct packed {
      word_type    num;
      word_type    den;
      logic        typed;
      cf_term_type fixed;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CALM_TAIL     = 30;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 120;

   // rows with a typed-in result carry typed = 1; the rest go to the predictor
   localparam stim_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
      '{32'h0000_002A, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
      '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
      '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 1'b1, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 1'b1, 1'b0}},
      '{32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
      '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'd355,       32'd113,       1'b0, '0},
      '{32'd113,       32'd355,       1'b0, '0},
      '{32'd2971215073, 32'd1836311903, 1'b0, '0},
      '{32'd1836311903, 32'd2971215073, 1'b0, '0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{32'd2,         32'd3,         1'b0, '0},
      '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'd100,       32'd7,         1'b0, '0}
   };

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_numerator = '0;
   word_type req_denominator = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_term;
   logic     rsp_last_term;
   logic     rsp_divide_error;

   // side info that travels with the offered item
   logic        cur_typed = 1'b0;
   cf_term_type cur_fixed = '0;

   cf_term_type expected_terms [$];
   cf_term_type oldest_term;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   bit          calm_tail = 1'b0;
   bit          stall_mode = 1'b0;

   rational_to_continued_fraction_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_numerator    (req_numerator),
      .req_denominator  (req_denominator),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_term         (rsp_term),
      .rsp_last_term    (rsp_last_term),
      .rsp_divide_error (rsp_divide_error)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Euclid expansion: quotient, then swap divisor and remainder until exact
   function automatic void expand_fraction(input word_type num, input word_type den);
      word_type dividend;
      word_type divisor;
      word_type quot;
      word_type rem;
      if (den == '0) begin
         expected_terms.push_back(cf_term_type'{'0, 1'b1, 1'b1});
      end else if (num == '0) begin
         expected_terms.push_back(cf_term_type'{'0, 1'b1, 1'b0});
      end else begin
         if (num < den) begin
            expected_terms.push_back(cf_term_type'{'0, 1'b0, 1'b0});
            dividend = den;
            divisor  = num;
         end else begin
            dividend = num;
            divisor  = den;
         end
         do begin
            quot = dividend / divisor;
            rem  = dividend % divisor;
            expected_terms.push_back(cf_term_type'{quot, rem == '0, 1'b0});
            dividend = divisor;
            divisor  = rem;
         end while (rem != '0);
      end
   endfunction

   task automatic report_mismatch(input string what, input word_type want,
                                  input word_type got);
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_terms.size() == 0) begin
            report_mismatch("unexpected result term", '0, rsp_term);
         end else begin
            oldest_term = expected_terms.pop_front();
            if (rsp_term !== oldest_term.term)
               report_mismatch("term", oldest_term.term, rsp_term);
            if (rsp_last_term !== oldest_term.last_term)
               report_mismatch("last_term", word_type'(oldest_term.last_term),
                               word_type'(rsp_last_term));
            if (rsp_divide_error !== oldest_term.divide_error)
               report_mismatch("divide_error", word_type'(oldest_term.divide_error),
                               word_type'(rsp_divide_error));
         end
      end
      if (!reset && req_valid && !req_stall) begin
         if (cur_typed)
            expected_terms.push_back(cur_fixed);
         else
            expand_fraction(req_numerator, req_denominator);
      end
   end

   // watchdog: count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("rational_to_continued_fraction_unit regression: fail");
            $finish;
         end
      end
   end

   // result-side stall bursts, switching between busy and calm stretches
   initial begin
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) == 0)
            stall_mode = ~stall_mode;
         if (!calm_tail && stall_mode && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer_item(input word_type num, input word_type den, input logic typed,
                             input cf_term_type fixed);
      @(negedge clock);
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_numerator   <= num;
      req_denominator <= den;
      cur_typed       <= typed;
      cur_fixed       <= fixed;
      // hold until the item is taken
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pick_operands(output word_type num, output word_type den);
      int unsigned pick;
      int unsigned steps;
      word_type a;
      word_type b;
      word_type c;
      pick = $urandom_range(0, 99);
      num  = $urandom;
      den  = $urandom;
      if (pick < 40) begin
         // full-range operands as drawn
      end else if (pick < 55) begin
         num = $urandom_range(1, 1000);
         den = $urandom_range(1, 1000);
      end else if (pick < 67) begin
         // consecutive Fibonacci numbers give the longest expansions
         a = 1;
         b = 1;
         steps = $urandom_range(1, 45);
         repeat (steps) begin
            c = a + b;
            a = b;
            b = c;
         end
         if ($urandom_range(0, 1) == 0) begin
            num = b;
            den = a;
         end else begin
            num = a;
            den = b;
         end
      end else if (pick < 77) begin
         num = den >> $urandom_range(1, 31);
         if (num == '0)
            num = 1;
      end else if (pick < 82) begin
         den = '0;
      end else if (pick < 87) begin
         num = '0;
      end else if (pick < 93) begin
         den = $urandom_range(1, 65535);
         num = den * $urandom_range(1, 65535);
      end else begin
         num = 32'hFFFF_FFFF - $urandom_range(0, 3);
         if ($urandom_range(0, 1) == 0)
            den = $urandom_range(1, 3);
         else
            den = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end
   endtask

   initial begin
      word_type num;
      word_type den;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_item(DIRECTED[i].num, DIRECTED[i].den, DIRECTED[i].typed,
                    DIRECTED[i].fixed);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - CALM_TAIL)
            calm_tail = 1'b1;
         pick_operands(num, den);
         offer_item(num, den, 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;

      while (expected_terms.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("rational_to_continued_fraction_unit regression: pass");
      else
         $display("rational_to_continued_fraction_unit regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
sv/rtcf_pkg.sv
sv/rtcf_front.sv
sv/rtcf_queue.sv
sv/rtcf_back.sv
sv/rational_to_continued_fraction_unit.sv
sim/rational_to_continued_fraction_unit_test.sv
